/* rtl/yaz0_pkg.sv */
// shared constants, types and helpers for the yaz0 decoder
`timescale 1ns / 1ps
package yaz0_pkg;

  localparam int WINDOW_SIZE = 4096;
  localparam int OUT_LANES   = 8;
  localparam int HIST_AW     = $clog2(WINDOW_SIZE);
  localparam int DIST_W      = HIST_AW + 1;
  localparam int LEN_W       = 9;

  localparam logic [4:0]       HDR_LAST_IDX  = 5'd15;
  localparam logic [LEN_W-1:0] REF2_LEN_BASE = LEN_W'(2);
  localparam logic [LEN_W-1:0] REF3_LEN_BASE = LEN_W'(8'h12);
  localparam logic [3:0]       FLAG_GROUP    = 4'd8;

  typedef enum logic [1:0] {
    ST_DATA      = 2'd0,
    ST_BAD_MAGIC = 2'd1,
    ST_SKIP_BIG  = 2'd2
  } status_t;

  typedef enum logic {
    CFG_SKIP_BYTES = 1'b0,
    CFG_OUT_LIMIT  = 1'b1
  } cfg_index_t;

  // controller to datapath
  typedef struct packed {
    logic    latch;
    logic    clear;
    logic    hdr;
    logic    flags;
    logic    shift;
    logic    pend;
    logic    ref2;
    logic    ref3;
    logic    rd;
    logic    put;
    logic    put_ram;
    logic    fail;
    status_t fail_code;
    logic    flush;
    logic    last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hdr_bad;
    logic hdr_done;
    logic limit_zero;
    logic skip_big;
    logic size_zero;
    logic flag_top;
    logic flags_end;
    logic nib_zero;
    logic put_done;
    logic put_full;
    logic put_any;
    logic len_one;
    logic len_zero;
    logic out_free;
  } sts_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = 8'h59; // Y
      2'd1:    m = 8'h61; // a
      2'd2:    m = 8'h7a; // z
      default: m = 8'h30; // 0
    endcase
    return m;
  endfunction

endpackage

/* rtl/yaz0_ram.sv */
// generic single-write, single-read ram with registered read
`timescale 1ns / 1ps
module yaz0_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/yaz0_dp.sv */
// yaz0 datapath: header fields, counters, history, lane packing, output register
`timescale 1ns / 1ps
module yaz0_dp (
  input  logic                clk,
  input  logic                rst,
  input  yaz0_pkg::cmd_t      cmd,
  output yaz0_pkg::sts_t      sts,
  input  logic [7:0]          in_byte,
  input  logic                cfg_wen,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_wdata,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [63:0]         out_bytes,
  output logic [3:0]          out_count,
  output logic [1:0]          status,
  output logic                out_last
);
  import yaz0_pkg::*;

  logic [31:0]        skip_bytes;
  logic [31:0]        out_limit;
  logic [7:0]         in_q;
  logic [4:0]         hdr_idx;
  logic [31:0]        decoded_size;
  logic [31:0]        produced;
  logic [31:0]        emitted;
  logic [7:0]         flag_bits;
  logic [3:0]         flags_left;
  logic [7:0]         pending;
  logic [DIST_W-1:0]  ref_dist;
  logic [LEN_W-1:0]   len;
  logic [63:0]        acc;
  logic [3:0]         acc_cnt;
  status_t            status_q;

  logic [7:0]         ram_rdata;
  logic [7:0]         pb;
  logic               emit;
  logic [31:0]        emitted_inc;

  assign pb          = cmd.put_ram ? ram_rdata : in_q;
  assign emit        = (produced >= skip_bytes) && (emitted < out_limit);
  assign emitted_inc = emitted + 32'(emit);

  always_comb begin
    sts            = '0;
    sts.hdr_bad    = (hdr_idx < 5'd4) && (in_q != magic_byte(hdr_idx[1:0]));
    sts.hdr_done   = (hdr_idx == HDR_LAST_IDX);
    sts.limit_zero = (out_limit == 32'd0);
    sts.skip_big   = (skip_bytes > decoded_size);
    sts.size_zero  = (decoded_size == 32'd0);
    sts.flag_top   = flag_bits[7];
    sts.flags_end  = (flags_left == 4'd1);
    sts.nib_zero   = (pending[7:4] == 4'd0);
    sts.put_done   = ((produced + 32'd1) == decoded_size) || (emitted_inc >= out_limit);
    sts.put_full   = emit && (acc_cnt == 4'(OUT_LANES - 1));
    sts.put_any    = emit || (acc_cnt != 4'd0);
    sts.len_one    = (len == LEN_W'(1));
    sts.len_zero   = (len == '0);
    sts.out_free   = !out_valid || !out_stall;
  end

  yaz0_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_SIZE)
  ) u_hist (
    .clk   (clk),
    .we    (cmd.put),
    .waddr (produced[HIST_AW-1:0]),
    .wdata (pb),
    .re    (cmd.rd),
    .raddr (produced[HIST_AW-1:0] - ref_dist[HIST_AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_bytes   <= '0;
      out_limit    <= '1;
      hdr_idx      <= '0;
      decoded_size <= '0;
      produced     <= '0;
      emitted      <= '0;
      flag_bits    <= '0;
      flags_left   <= '0;
      len          <= '0;
      acc          <= '0;
      acc_cnt      <= '0;
      status_q     <= ST_DATA;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          CFG_SKIP_BYTES: skip_bytes <= cfg_wdata;
          CFG_OUT_LIMIT:  out_limit  <= cfg_wdata;
          default:        skip_bytes <= skip_bytes;
        endcase
      end
      if (cmd.latch) begin
        in_q <= in_byte;
      end
      if (cmd.clear) begin
        hdr_idx      <= '0;
        decoded_size <= '0;
        produced     <= '0;
        emitted      <= '0;
        flag_bits    <= '0;
        flags_left   <= '0;
        pending      <= '0;
        ref_dist     <= '0;
        len          <= '0;
      end
      if (cmd.hdr) begin
        hdr_idx <= hdr_idx + 5'd1;
        if (hdr_idx inside {[5'd4:5'd7]}) begin
          decoded_size <= {decoded_size[23:0], in_q};
        end
      end
      if (cmd.flags) begin
        flag_bits  <= in_q;
        flags_left <= FLAG_GROUP;
      end
      if (cmd.shift) begin
        flag_bits  <= {flag_bits[6:0], 1'b0};
        flags_left <= flags_left - 4'd1;
      end
      if (cmd.pend) begin
        pending <= in_q;
      end
      if (cmd.ref2) begin
        ref_dist <= {1'b0, pending[3:0], in_q} + DIST_W'(1);
        if (pending[7:4] != 4'd0) begin
          len <= LEN_W'(pending[7:4]) + REF2_LEN_BASE;
        end
      end
      if (cmd.ref3) begin
        len <= LEN_W'(in_q) + REF3_LEN_BASE;
      end
      if (cmd.put) begin
        produced <= produced + 32'd1;
        if (emit) begin
          emitted                  <= emitted_inc;
          acc[acc_cnt[2:0]*8 +: 8] <= pb;
          acc_cnt                  <= acc_cnt + 4'd1;
        end
        if (cmd.put_ram) begin
          len <= len - LEN_W'(1);
        end
      end
      if (cmd.fail) begin
        status_q <= cmd.fail_code;
      end
      if (cmd.flush) begin
        out_valid <= 1'b1;
        out_bytes <= acc;
        out_count <= acc_cnt;
        status    <= status_q;
        out_last  <= cmd.last;
        acc       <= '0;
        acc_cnt   <= '0;
        status_q  <= ST_DATA;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_acc_bound: assert property (@(posedge clk) disable iff (rst)
    acc_cnt <= 4'(OUT_LANES)) else $error("lane count overflow");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_count == 4'd0) |-> out_last)
    else $error("status-only result without last");

  a_error_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_DATA) |-> (out_count == 4'd0) && out_last)
    else $error("error result carries data");

endmodule

/* rtl/yaz0_ctrl.sv */
// yaz0 controller: token phase, finish flag and step sequencing
`timescale 1ns / 1ps
module yaz0_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            frame_start,
  output logic            in_stall,
  input  yaz0_pkg::sts_t  sts,
  output yaz0_pkg::cmd_t  cmd
);
  import yaz0_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_CREAD, S_CWRITE, S_FLUSH
  } state_t;

  typedef enum logic [2:0] {
    P_HEADER, P_FLAGS, P_TOKEN, P_REF2, P_REF3
  } phase_t;

  state_t state, state_next;
  phase_t phase, phase_next;
  logic   finished, finished_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.fail_code = ST_DATA;
    state_next    = state;
    phase_next    = phase;
    finished_next = finished;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          cmd.clear  = frame_start;
          state_next = S_DECODE;
          if (frame_start) begin
            phase_next    = P_HEADER;
            finished_next = 1'b0;
          end
        end
      end
      S_DECODE: begin
        state_next = S_IDLE;
        if (!finished) begin
          case (phase)
            P_HEADER: begin
              cmd.hdr = 1'b1;
              if (sts.hdr_bad) begin
                cmd.fail      = 1'b1;
                cmd.fail_code = ST_BAD_MAGIC;
                finished_next = 1'b1;
                state_next    = S_FLUSH;
              end else if (sts.hdr_done) begin
                if (sts.limit_zero) begin
                  finished_next = 1'b1;
                end else if (sts.skip_big) begin
                  cmd.fail      = 1'b1;
                  cmd.fail_code = ST_SKIP_BIG;
                  finished_next = 1'b1;
                  state_next    = S_FLUSH;
                end else if (sts.size_zero) begin
                  finished_next = 1'b1;
                  state_next    = S_FLUSH;
                end else begin
                  phase_next = P_FLAGS;
                end
              end
            end
            P_FLAGS: begin
              cmd.flags  = 1'b1;
              phase_next = P_TOKEN;
            end
            P_TOKEN: begin
              if (sts.flag_top) begin
                cmd.shift  = 1'b1;
                cmd.put    = 1'b1;
                phase_next = sts.flags_end ? P_FLAGS : P_TOKEN;
                if (sts.put_done) begin
                  finished_next = 1'b1;
                  state_next    = S_FLUSH;
                end else if (sts.put_any) begin
                  state_next = S_FLUSH;
                end
              end else begin
                cmd.pend   = 1'b1;
                phase_next = P_REF2;
              end
            end
            P_REF2: begin
              cmd.ref2 = 1'b1;
              if (sts.nib_zero) begin
                phase_next = P_REF3;
              end else begin
                cmd.shift  = 1'b1;
                phase_next = sts.flags_end ? P_FLAGS : P_TOKEN;
                state_next = S_CREAD;
              end
            end
            P_REF3: begin
              cmd.ref3   = 1'b1;
              cmd.shift  = 1'b1;
              phase_next = sts.flags_end ? P_FLAGS : P_TOKEN;
              state_next = S_CREAD;
            end
            default: phase_next = P_HEADER;
          endcase
        end
      end
      S_CREAD: begin
        cmd.rd     = 1'b1;
        state_next = S_CWRITE;
      end
      S_CWRITE: begin
        cmd.put     = 1'b1;
        cmd.put_ram = 1'b1;
        if (sts.put_done) begin
          finished_next = 1'b1;
          state_next    = S_FLUSH;
        end else if (sts.put_full) begin
          state_next = S_FLUSH;
        end else if (sts.len_one) begin
          state_next = sts.put_any ? S_FLUSH : S_IDLE;
        end else begin
          state_next = S_CREAD;
        end
      end
      S_FLUSH: begin
        if (sts.out_free) begin
          cmd.flush = 1'b1;
          cmd.last  = finished;
          if (finished || sts.len_zero) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_CREAD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      phase    <= P_HEADER;
      finished <= 1'b1;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      finished <= finished_next;
    end
  end

  a_flush_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |-> sts.out_free) else $error("flush into a busy output register");

  a_read_then_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_CREAD) |=> (state == S_CWRITE)) else $error("history read not followed by copy");

  a_put_not_flush: assert property (@(posedge clk) disable iff (rst)
    !(cmd.put && cmd.flush)) else $error("put and flush in one cycle");

endmodule

/* rtl/yaz0_lz_decoder.sv */
// top level of the yaz0 decoder: controller plus datapath
// an input byte is latched in S_IDLE and decoded in S_DECODE in the cycle after; a literal
//   with bytes to send also passes S_FLUSH for its result transaction; a reference starts a copy
// a back-reference copies each history byte by a ram read in S_CREAD, then a write in S_CWRITE,
//   passing S_FLUSH for each result transaction; a copy is at most 273 bytes
// reset: synchronous, clears control state; the decoder sits finished until frame_start
// the 4 KiB history is not cleared; the block does not check that reads stay behind bytes this file produced
`timescale 1ns / 1ps
module yaz0_lz_decoder (
  input  logic        clk,
  input  logic        rst,
  // compressed input, one byte per transaction
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        frame_start,
  // configuration writes
  input  logic        cfg_wen,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  // decoded output, up to eight bytes per transaction
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_bytes,
  output logic [3:0]  out_count,
  output logic [1:0]  status,
  output logic        out_last
);
  import yaz0_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing: header check, flag groups, literal and copy steps
  yaz0_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .frame_start (frame_start),
    .in_stall    (in_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  // counters, history ram, lane packing and the output register
  yaz0_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_byte   (in_byte),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_bytes (out_bytes),
    .out_count (out_count),
    .status    (status),
    .out_last  (out_last)
  );

endmodule
